// File: rtl/dihed_pkg.sv
// shared types, widths and constants for the dihedral angle pipeline
package dihed_pkg;

    localparam int COORD_W   = 20;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int PROD_W    = SQ_W + 1;
    localparam int LO_W      = 22;
    localparam int HI_W      = PROD_W - LO_W;
    localparam int DP_W      = 2 * PROD_W;
    localparam int DOT_W     = DP_W + 2;
    localparam int TR_W      = 64;
    localparam int ZZ_W      = SQ_W;
    localparam int SQRT_FRAC = 20;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 31;
    localparam int XMAG_SHIFT = 10;
    localparam int MAG_W     = DOT_W + XMAG_SHIFT;
    localparam int HALF_W    = 32;
    localparam int NORM_W    = 30;
    localparam int XY_W      = 34;
    localparam int ACC_W     = 25;
    localparam int ANGLE_W   = 17;
    localparam int ROUND_SHIFT = 8;

    localparam int FRONT_ZZ_LAT = 3;
    localparam int FRONT_LAT    = 7;
    localparam int SQRT_STAGES  = RAD_W / 4;
    localparam int NORM_STEPS   = 7;
    localparam int SCALE_LAT    = 2 + NORM_STEPS;
    localparam int RESULT_LAT_BASE = FRONT_ZZ_LAT + SQRT_STAGES + SCALE_LAT + 2;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int HALF_TURN   = 23040;
    localparam int FULL_TURN   = 46080;
    localparam int QUARTER_ACC = 90 * 32768;
    localparam logic signed [ANGLE_W-1:0] ANGLE_UNDEF = ANGLE_W'(FULL_TURN);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } dihed_pt_t;

    typedef struct packed {
        logic       x_neg;
        logic       y_neg;
        logic       undef;
    } dihed_side_t;

    typedef struct packed {
        logic [DOT_W-1:0] d_mag;
        logic [TR_W-1:0]  tr_mag;
        dihed_side_t      side;
    } dihed_prod_t;

    typedef struct packed {
        logic [NORM_W-1:0] xm;
        logic [NORM_W-1:0] ym;
        dihed_side_t       side;
    } dihed_norm_t;

    // arctangent of 2^-i in 2^-15 degree, rounded to nearest
    function automatic logic [20:0] atan_entry(input int unsigned idx);
        logic [20:0] v;
        case (idx)
            0:  v = 21'd1474560;
            1:  v = 21'd870484;
            2:  v = 21'd459940;
            3:  v = 21'd233473;
            4:  v = 21'd117189;
            5:  v = 21'd58652;
            6:  v = 21'd29333;
            7:  v = 21'd14667;
            8:  v = 21'd7334;
            9:  v = 21'd3667;
            10: v = 21'd1833;
            11: v = 21'd917;
            12: v = 21'd458;
            13: v = 21'd229;
            14: v = 21'd115;
            15: v = 21'd57;
            16: v = 21'd29;
            17: v = 21'd14;
            18: v = 21'd7;
            19: v = 21'd4;
            20: v = 21'd2;
            21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/dihed_front.sv
// difference vectors, cross products, dot and triple products and axis length squared
module dihed_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  dihed_pkg::dihed_pt_t          pt1,
    input  dihed_pkg::dihed_pt_t          pt2,
    input  dihed_pkg::dihed_pt_t          pt3,
    input  dihed_pkg::dihed_pt_t          pt4,
    output logic                          zz_valid,
    output logic [dihed_pkg::ZZ_W-1:0]    zz,
    output dihed_pkg::dihed_prod_t        prod
);

    localparam int DIFF_W = dihed_pkg::DIFF_W;
    localparam int SQ_W   = dihed_pkg::SQ_W;
    localparam int PROD_W = dihed_pkg::PROD_W;
    localparam int LO_W   = dihed_pkg::LO_W;
    localparam int HI_W   = dihed_pkg::HI_W;
    localparam int DP_W   = dihed_pkg::DP_W;
    localparam int DOT_W  = dihed_pkg::DOT_W;
    localparam int TR_W   = dihed_pkg::TR_W;
    localparam int ZZ_W   = dihed_pkg::ZZ_W;
    localparam int PP_W   = HI_W + LO_W + 1;

    logic vld_reg [dihed_pkg::FRONT_ZZ_LAT];

    logic signed [DIFF_W-1:0] a_next [3];
    logic signed [DIFF_W-1:0] b_next [3];
    logic signed [DIFF_W-1:0] z_next [3];
    logic signed [DIFF_W-1:0] a_reg  [3];
    logic signed [DIFF_W-1:0] b_reg  [3];
    logic signed [DIFF_W-1:0] z_reg  [3];

    logic signed [SQ_W-1:0]   pm_reg [3];
    logic signed [SQ_W-1:0]   pn_reg [3];
    logic signed [SQ_W-1:0]   qm_reg [3];
    logic signed [SQ_W-1:0]   qn_reg [3];
    logic signed [SQ_W-1:0]   zsq_reg [3];
    logic signed [DIFF_W-1:0] b2_reg [3];

    logic signed [PROD_W-1:0] p_reg  [3];
    logic signed [PROD_W-1:0] q_reg  [3];
    logic [ZZ_W-1:0]          zz_reg;
    logic signed [DIFF_W-1:0] b3_reg [3];

    logic signed [HI_W-1:0]   ph [3];
    logic signed [HI_W-1:0]   qh [3];
    logic [LO_W-1:0]          pl [3];
    logic [LO_W-1:0]          ql [3];

    logic signed [SQ_W-1:0]   hh_reg [3];
    logic signed [PP_W-1:0]   hl_reg [3];
    logic signed [PP_W-1:0]   lh_reg [3];
    logic [PP_W-1:0]          ll_reg [3];
    logic signed [SQ_W-1:0]   tbh_reg [3];
    logic signed [PP_W-1:0]   tbl_reg [3];
    logic                     qz4_reg;

    logic signed [DP_W-1:0]   dp_reg [3];
    logic signed [TR_W-1:0]   trp_reg [3];
    logic                     qz5_reg;

    logic signed [DOT_W-1:0]  d_reg;
    logic signed [TR_W-1:0]   tr_reg;
    logic                     qz6_reg;

    dihed_pkg::dihed_prod_t   prod_next;
    dihed_pkg::dihed_prod_t   prod_reg;

    always_comb
    begin
        a_next[0] = DIFF_W'(pt1.x) - DIFF_W'(pt2.x);
        a_next[1] = DIFF_W'(pt1.y) - DIFF_W'(pt2.y);
        a_next[2] = DIFF_W'(pt1.z) - DIFF_W'(pt2.z);
        b_next[0] = DIFF_W'(pt4.x) - DIFF_W'(pt3.x);
        b_next[1] = DIFF_W'(pt4.y) - DIFF_W'(pt3.y);
        b_next[2] = DIFF_W'(pt4.z) - DIFF_W'(pt3.z);
        z_next[0] = DIFF_W'(pt2.x) - DIFF_W'(pt3.x);
        z_next[1] = DIFF_W'(pt2.y) - DIFF_W'(pt3.y);
        z_next[2] = DIFF_W'(pt2.z) - DIFF_W'(pt3.z);
    end

    // split each cross component into a signed high part and unsigned low part
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ph[i] = $signed(p_reg[i][PROD_W-1:LO_W]);
            pl[i] = p_reg[i][LO_W-1:0];
            qh[i] = $signed(q_reg[i][PROD_W-1:LO_W]);
            ql[i] = q_reg[i][LO_W-1:0];
        end
    end

    always_comb
    begin
        prod_next.side.x_neg = d_reg[DOT_W-1];
        prod_next.side.y_neg = !tr_reg[TR_W-1] && (tr_reg != '0);
        prod_next.side.undef = qz6_reg || ((d_reg == '0) && (tr_reg == '0));
        prod_next.d_mag      = d_reg[DOT_W-1] ? DOT_W'(-d_reg) : DOT_W'(d_reg);
        prod_next.tr_mag     = tr_reg[TR_W-1] ? TR_W'(-tr_reg) : TR_W'(tr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dihed_pkg::FRONT_ZZ_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < dihed_pkg::FRONT_ZZ_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        z_reg <= z_next;

        pm_reg[0] <= z_reg[1] * a_reg[2];
        pn_reg[0] <= a_reg[1] * z_reg[2];
        pm_reg[1] <= z_reg[2] * a_reg[0];
        pn_reg[1] <= a_reg[2] * z_reg[0];
        pm_reg[2] <= z_reg[0] * a_reg[1];
        pn_reg[2] <= a_reg[0] * z_reg[1];
        qm_reg[0] <= z_reg[1] * b_reg[2];
        qn_reg[0] <= b_reg[1] * z_reg[2];
        qm_reg[1] <= z_reg[2] * b_reg[0];
        qn_reg[1] <= b_reg[2] * z_reg[0];
        qm_reg[2] <= z_reg[0] * b_reg[1];
        qn_reg[2] <= b_reg[0] * z_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            zsq_reg[i] <= z_reg[i] * z_reg[i];
            b2_reg[i]  <= b_reg[i];
        end

        for (int i = 0; i < 3; i++)
        begin
            p_reg[i]  <= PROD_W'(pm_reg[i]) - PROD_W'(pn_reg[i]);
            q_reg[i]  <= PROD_W'(qm_reg[i]) - PROD_W'(qn_reg[i]);
            b3_reg[i] <= b2_reg[i];
        end
        zz_reg <= ZZ_W'(zsq_reg[0]) + ZZ_W'(zsq_reg[1]) + ZZ_W'(zsq_reg[2]);

        for (int i = 0; i < 3; i++)
        begin
            hh_reg[i]  <= ph[i] * qh[i];
            hl_reg[i]  <= ph[i] * $signed({1'b0, ql[i]});
            lh_reg[i]  <= $signed({1'b0, pl[i]}) * qh[i];
            ll_reg[i]  <= pl[i] * ql[i];
            tbh_reg[i] <= ph[i] * b3_reg[i];
            tbl_reg[i] <= $signed({1'b0, pl[i]}) * b3_reg[i];
        end
        qz4_reg <= (q_reg[0] == '0) && (q_reg[1] == '0) && (q_reg[2] == '0);

        for (int i = 0; i < 3; i++)
        begin
            dp_reg[i]  <= (DP_W'(hh_reg[i]) << (2 * LO_W))
                        + ((DP_W'(hl_reg[i]) + DP_W'(lh_reg[i])) << LO_W)
                        + DP_W'(ll_reg[i]);
            trp_reg[i] <= (TR_W'(tbh_reg[i]) << LO_W) + TR_W'(tbl_reg[i]);
        end
        qz5_reg <= qz4_reg;

        d_reg   <= DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
        tr_reg  <= trp_reg[0] + trp_reg[1] + trp_reg[2];
        qz6_reg <= qz5_reg;

        prod_reg <= prod_next;
    end

    assign zz_valid = vld_reg[dihed_pkg::FRONT_ZZ_LAT-1];
    assign zz       = zz_reg;
    assign prod     = prod_reg;

endmodule

// File: rtl/dihed_isqrt.sv
// pipelined integer square root, two result bits per stage
module dihed_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [dihed_pkg::RAD_W-1:0]  radicand,
    output logic                         out_valid,
    output logic [dihed_pkg::ROOT_W-1:0] root
);

    localparam int RAD_W  = dihed_pkg::RAD_W;
    localparam int STAGES = dihed_pkg::SQRT_STAGES;
    localparam int QW     = RAD_W / 2;
    localparam int REM_W  = QW + 3;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    root;
    } sq_t;

    function automatic sq_t sq_step(input logic [REM_W-1:0] rem, input logic [QW-1:0] rt,
                                    input logic [1:0] pair);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        sq_t              res;
        r = {rem[REM_W-3:0], pair};
        t = {1'b0, rt, 2'b01};
        if (r >= t)
        begin
            res.rem  = r - t;
            res.root = {rt[QW-2:0], 1'b1};
        end
        else
        begin
            res.rem  = r;
            res.root = {rt[QW-2:0], 1'b0};
        end
        return res;
    endfunction

    logic             vld_reg  [STAGES];
    logic [RAD_W-1:0] src_reg  [STAGES];
    logic [REM_W-1:0] rem_reg  [STAGES];
    logic [QW-1:0]    root_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic             vin;
        logic [RAD_W-1:0] sin;
        logic [REM_W-1:0] rin;
        logic [QW-1:0]    qin;
        sq_t              mid;
        sq_t              st_next;

        if (s == 0)
        begin : g_first
            assign vin = in_valid;
            assign sin = radicand;
            assign rin = '0;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign vin = vld_reg[s-1];
            assign sin = src_reg[s-1];
            assign rin = rem_reg[s-1];
            assign qin = root_reg[s-1];
        end

        always_comb
        begin
            mid     = sq_step(rin, qin, sin[RAD_W-1-4*s -: 2]);
            st_next = sq_step(mid.rem, mid.root, sin[RAD_W-3-4*s -: 2]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            src_reg[s]  <= sin;
            rem_reg[s]  <= st_next.rem;
            root_reg[s] <= st_next.root;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign root      = root_reg[STAGES-1][dihed_pkg::ROOT_W-1:0];

endmodule

// File: rtl/dihed_scale.sv
// scales the triple product by the axis length, shifts the dot product up and normalizes the pair to 30 bits
module dihed_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  dihed_pkg::dihed_prod_t       prod,
    input  logic [dihed_pkg::ROOT_W-1:0] zs,
    output logic                         out_valid,
    output dihed_pkg::dihed_norm_t       norm
);

    localparam int MAG_W  = dihed_pkg::MAG_W;
    localparam int HALF_W = dihed_pkg::HALF_W;
    localparam int YP_W   = HALF_W + dihed_pkg::ROOT_W;
    localparam int STEPS  = dihed_pkg::NORM_STEPS;
    localparam int NORM_W = dihed_pkg::NORM_W;

    logic                        v1_reg;
    logic [YP_W-1:0]             ylo_reg;
    logic [YP_W-1:0]             yhi_reg;
    logic [dihed_pkg::DOT_W-1:0] dmag1_reg;
    dihed_pkg::dihed_side_t      side1_reg;

    logic                        v2_reg;
    logic [MAG_W-1:0]            xmag_reg;
    logic [MAG_W-1:0]            ymag_reg;
    dihed_pkg::dihed_side_t      side2_reg;

    logic                        nv_reg   [STEPS];
    logic [MAG_W-1:0]            nx_reg   [STEPS];
    logic [MAG_W-1:0]            ny_reg   [STEPS];
    dihed_pkg::dihed_side_t      nside_reg [STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ylo_reg   <= prod.tr_mag[HALF_W-1:0] * zs;
        yhi_reg   <= prod.tr_mag[2*HALF_W-1:HALF_W] * zs;
        dmag1_reg <= prod.d_mag;
        side1_reg <= prod.side;

        xmag_reg  <= {dmag1_reg, {dihed_pkg::XMAG_SHIFT{1'b0}}};
        ymag_reg  <= (MAG_W'(yhi_reg) << HALF_W) + MAG_W'(ylo_reg);
        side2_reg <= side1_reg;
    end

    // one common right shift, largest power of two first
    for (genvar k = 0; k < STEPS; k++)
    begin : g_norm
        localparam int W = 1 << (STEPS - 1 - k);
        logic                   vin;
        logic [MAG_W-1:0]       xin;
        logic [MAG_W-1:0]       yin;
        dihed_pkg::dihed_side_t sin;
        logic                   big;

        if (k == 0)
        begin : g_first
            assign vin = v2_reg;
            assign xin = xmag_reg;
            assign yin = ymag_reg;
            assign sin = side2_reg;
        end
        else
        begin : g_rest
            assign vin = nv_reg[k-1];
            assign xin = nx_reg[k-1];
            assign yin = ny_reg[k-1];
            assign sin = nside_reg[k-1];
        end

        assign big = ((xin | yin) >> (NORM_W - 1 + W)) != '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nv_reg[k] <= 1'b0;
            end
            else
            begin
                nv_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            nx_reg[k]    <= big ? (xin >> W) : xin;
            ny_reg[k]    <= big ? (yin >> W) : yin;
            nside_reg[k] <= sin;
        end
    end

    assign out_valid = nv_reg[STEPS-1];
    assign norm.xm   = nx_reg[STEPS-1][NORM_W-1:0];
    assign norm.ym   = ny_reg[STEPS-1][NORM_W-1:0];
    assign norm.side = nside_reg[STEPS-1];

endmodule

// File: rtl/dihed_cordic.sv
// vectoring cordic, one rotation per stage, with rounding and wrap to a half turn
module dihed_cordic #(
    parameter int STEPS = dihed_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  dihed_pkg::dihed_norm_t               norm,
    output logic                                 done,
    output logic signed [dihed_pkg::ANGLE_W-1:0] angle,
    output logic                                 undefined
);

    localparam int XY_W    = dihed_pkg::XY_W;
    localparam int ACC_W   = dihed_pkg::ACC_W;
    localparam int ANGLE_W = dihed_pkg::ANGLE_W;
    localparam logic signed [ACC_W-1:0] QUARTER = ACC_W'(dihed_pkg::QUARTER_ACC);
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(dihed_pkg::HALF_TURN);
    localparam logic signed [ACC_W-1:0] FULL    = ACC_W'(dihed_pkg::FULL_TURN);
    localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1 << (dihed_pkg::ROUND_SHIFT - 1));

    logic signed [XY_W-1:0]  cx_reg [STEPS+1];
    logic signed [XY_W-1:0]  cy_reg [STEPS+1];
    logic signed [ACC_W-1:0] ca_reg [STEPS+1];
    logic                    cv_reg [STEPS+1];
    logic                    cu_reg [STEPS+1];

    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [XY_W-1:0]  x0_next;
    logic signed [XY_W-1:0]  y0_next;
    logic signed [ACC_W-1:0] a0_next;

    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] wrapped;
    logic signed [ANGLE_W-1:0] angle_next;

    logic                      done_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      undef_reg;

    // fold the left half plane onto the right half
    always_comb
    begin
        xs = norm.side.x_neg ? XY_W'(-XY_W'(norm.xm)) : XY_W'(norm.xm);
        ys = norm.side.y_neg ? XY_W'(-XY_W'(norm.ym)) : XY_W'(norm.ym);
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x0_next = ys;
                y0_next = -xs;
                a0_next = QUARTER;
            end
            else
            begin
                x0_next = -ys;
                y0_next = xs;
                a0_next = -QUARTER;
            end
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            a0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= x0_next;
        cy_reg[0] <= y0_next;
        ca_reg[0] <= a0_next;
        cu_reg[0] <= norm.side.undef;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        logic signed [XY_W-1:0]  dx;
        logic signed [XY_W-1:0]  dy;
        logic signed [ACC_W-1:0] at;
        logic signed [XY_W-1:0]  x_next;
        logic signed [XY_W-1:0]  y_next;
        logic signed [ACC_W-1:0] a_next;

        always_comb
        begin
            dx = cy_reg[i] >>> i;
            dy = cx_reg[i] >>> i;
            at = ACC_W'(dihed_pkg::atan_entry(i));
            if (cy_reg[i] > 0)
            begin
                x_next = cx_reg[i] + dx;
                y_next = cy_reg[i] - dy;
                a_next = ca_reg[i] + at;
            end
            else
            begin
                x_next = cx_reg[i] - dx;
                y_next = cy_reg[i] + dy;
                a_next = ca_reg[i] - at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[i+1] <= x_next;
            cy_reg[i+1] <= y_next;
            ca_reg[i+1] <= a_next;
            cu_reg[i+1] <= cu_reg[i];
        end
    end

    always_comb
    begin
        rnd = (ca_reg[STEPS] + RND) >>> dihed_pkg::ROUND_SHIFT;
        if (rnd <= -HALF)
        begin
            wrapped = rnd + FULL;
        end
        else if (rnd > HALF)
        begin
            wrapped = rnd - FULL;
        end
        else
        begin
            wrapped = rnd;
        end
        angle_next = cu_reg[STEPS] ? dihed_pkg::ANGLE_UNDEF : wrapped[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cv_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        undef_reg <= cu_reg[STEPS];
    end

    assign done      = done_reg;
    assign angle     = angle_reg;
    assign undefined = undef_reg;

endmodule

// File: rtl/dihedral_angle_four_points.sv
// Torsion angle of four points about the second-to-third axis, fully pipelined.
// A transaction is taken in every cycle that start is high; busy stays low, and
// results leave in the order the transactions came in. Each result appears on
// angle and undefined for exactly one cycle with done high. The latency is
// set by the cordic chain, one rotation per stage, and by the 16-stage square
// root of the axis length, which runs alongside the cross and dot products.
module dihedral_angle_four_points #(
    parameter int CORDIC_STEPS = dihed_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [dihed_pkg::COORD_W-1:0]  first_x,
    input  logic signed [dihed_pkg::COORD_W-1:0]  first_y,
    input  logic signed [dihed_pkg::COORD_W-1:0]  first_z,
    input  logic signed [dihed_pkg::COORD_W-1:0]  second_x,
    input  logic signed [dihed_pkg::COORD_W-1:0]  second_y,
    input  logic signed [dihed_pkg::COORD_W-1:0]  second_z,
    input  logic signed [dihed_pkg::COORD_W-1:0]  third_x,
    input  logic signed [dihed_pkg::COORD_W-1:0]  third_y,
    input  logic signed [dihed_pkg::COORD_W-1:0]  third_z,
    input  logic signed [dihed_pkg::COORD_W-1:0]  fourth_x,
    input  logic signed [dihed_pkg::COORD_W-1:0]  fourth_y,
    input  logic signed [dihed_pkg::COORD_W-1:0]  fourth_z,
    output logic                                  done,
    output logic signed [dihed_pkg::ANGLE_W-1:0]  angle,
    output logic                                  undefined
);

    localparam int DLY = dihed_pkg::FRONT_ZZ_LAT + dihed_pkg::SQRT_STAGES
                       - dihed_pkg::FRONT_LAT;

    dihed_pkg::dihed_pt_t   pt1;
    dihed_pkg::dihed_pt_t   pt2;
    dihed_pkg::dihed_pt_t   pt3;
    dihed_pkg::dihed_pt_t   pt4;

    logic                        zz_valid;
    logic [dihed_pkg::ZZ_W-1:0]  zz;
    dihed_pkg::dihed_prod_t      prod;
    logic                        root_valid;
    logic [dihed_pkg::ROOT_W-1:0] root;
    dihed_pkg::dihed_prod_t      dly_reg [DLY];
    logic                        norm_valid;
    dihed_pkg::dihed_norm_t      norm;

    assign busy = 1'b0;

    assign pt1 = '{x: first_x,  y: first_y,  z: first_z};
    assign pt2 = '{x: second_x, y: second_y, z: second_z};
    assign pt3 = '{x: third_x,  y: third_y,  z: third_z};
    assign pt4 = '{x: fourth_x, y: fourth_y, z: fourth_z};

    dihed_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .pt1      (pt1),
        .pt2      (pt2),
        .pt3      (pt3),
        .pt4      (pt4),
        .zz_valid (zz_valid),
        .zz       (zz),
        .prod     (prod)
    );

    dihed_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (zz_valid),
        .radicand  (dihed_pkg::RAD_W'({zz, {dihed_pkg::SQRT_FRAC{1'b0}}})),
        .out_valid (root_valid),
        .root      (root)
    );

    // hold the dot and triple products until the axis length comes out of the root
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= prod;
        for (int k = 1; k < DLY; k++)
        begin
            dly_reg[k] <= dly_reg[k-1];
        end
    end

    dihed_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .prod      (dly_reg[DLY-1]),
        .zs        (root),
        .out_valid (norm_valid),
        .norm      (norm)
    );

    dihed_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .norm      (norm),
        .done      (done),
        .angle     (angle),
        .undefined (undefined)
    );

endmodule

// File: rtl/dihed_checker.sv
// port-level checks of the dihedral angle block and their bind
module dihed_checker #(
    parameter int CORDIC_STEPS = dihed_pkg::CORDIC_STEPS_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic signed [dihed_pkg::ANGLE_W-1:0] angle,
    input logic                                 undefined
);

    localparam int LAT = dihed_pkg::RESULT_LAT_BASE + CORDIC_STEPS;
    localparam logic signed [dihed_pkg::ANGLE_W-1:0] HALF =
        dihed_pkg::ANGLE_W'(dihed_pkg::HALF_TURN);

    // every transaction comes back after the fixed latency
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("transaction produced no result");

    // no result without a transaction
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without transaction");

    a_undef_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && undefined |-> angle == dihed_pkg::ANGLE_UNDEF)
        else $error("undefined result without sentinel angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !undefined |-> (angle > -HALF) && (angle <= HALF))
        else $error("angle outside half turn");

endmodule

bind dihedral_angle_four_points dihed_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_dihed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .angle     (angle),
    .undefined (undefined)
);

// File: tb/testbench.sv
// self-checking testbench for the dihedral angle pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS       = dihed_pkg::CORDIC_STEPS_DEF;
    localparam int DRAIN_WAIT  = STEPS + 60;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_N    = 1400;
    localparam int SMALL_SPAN  = 300;

    typedef struct packed {
        dihed_pkg::dihed_pt_t p1;
        dihed_pkg::dihed_pt_t p2;
        dihed_pkg::dihed_pt_t p3;
        dihed_pkg::dihed_pt_t p4;
    } quad_t;

    typedef struct packed {
        logic signed [dihed_pkg::ANGLE_W-1:0] ang;
        logic                                 undef;
    } torsion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    quad_t cur = '0;
    logic done;
    logic signed [dihed_pkg::ANGLE_W-1:0] angle;
    logic undefined;

    quad_t    pending_quads[$];
    torsion_t expected_torsions[$];

    int n_sent = 0, n_checked = 0, n_undef = 0, n_mismatch = 0;
    int burst_left = 0, gap_left = 0, idle_cycles = 0;

    dihedral_angle_four_points #(.CORDIC_STEPS(STEPS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_x(cur.p1.x), .first_y(cur.p1.y), .first_z(cur.p1.z),
        .second_x(cur.p2.x), .second_y(cur.p2.y), .second_z(cur.p2.z),
        .third_x(cur.p3.x), .third_y(cur.p3.y), .third_z(cur.p3.z),
        .fourth_x(cur.p4.x), .fourth_y(cur.p4.y), .fourth_z(cur.p4.z),
        .done(done), .angle(angle), .undefined(undefined)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [65:0] v, res, b;
        v = v_in;
        res = '0;
        b = 66'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[63:0];
    endfunction

    function automatic int bit_len(input logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
            if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic torsion_t torsion_of(input quad_t t);
        longint a[3], b[3], z[3], p[3], q[3], pa[3], pb[3], pc[3], pd[3];
        longint tr, zz, xs, ys, acc, dx, dy, tmp, ang;
        logic signed [127:0] dot;
        logic [127:0] xmag, ymag;
        logic [63:0] zs;
        int len, s;
        torsion_t r;
        pa[0] = t.p1.x; pa[1] = t.p1.y; pa[2] = t.p1.z;
        pb[0] = t.p2.x; pb[1] = t.p2.y; pb[2] = t.p2.z;
        pc[0] = t.p3.x; pc[1] = t.p3.y; pc[2] = t.p3.z;
        pd[0] = t.p4.x; pd[1] = t.p4.y; pd[2] = t.p4.z;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = pa[i] - pb[i];
            b[i] = pd[i] - pc[i];
            z[i] = pb[i] - pc[i];
        end
        p[0] = z[1] * a[2] - a[1] * z[2];
        p[1] = z[2] * a[0] - a[2] * z[0];
        p[2] = z[0] * a[1] - a[0] * z[1];
        q[0] = z[1] * b[2] - b[1] * z[2];
        q[1] = z[2] * b[0] - b[2] * z[0];
        q[2] = z[0] * b[1] - b[0] * z[1];
        dot = 128'(signed'(p[0])) * 128'(signed'(q[0]))
            + 128'(signed'(p[1])) * 128'(signed'(q[1]))
            + 128'(signed'(p[2])) * 128'(signed'(q[2]));
        // triple product fits in 64 bits
        tr = p[0] * b[0] + p[1] * b[1] + p[2] * b[2];
        if ((q[0] == 0 && q[1] == 0 && q[2] == 0) || (dot == 0 && tr == 0))
        begin
            r.ang = dihed_pkg::ANGLE_UNDEF;
            r.undef = 1'b1;
            return r;
        end
        zz = z[0] * z[0] + z[1] * z[1] + z[2] * z[2];
        zs = int_sqrt(64'(zz) << dihed_pkg::SQRT_FRAC);
        ymag = 128'(tr < 0 ? -tr : tr) * 128'(zs);
        xmag = (dot < 0 ? -dot : dot) << dihed_pkg::XMAG_SHIFT;
        len = bit_len(xmag);
        if (bit_len(ymag) > len) len = bit_len(ymag);
        s = len > dihed_pkg::NORM_W ? len - dihed_pkg::NORM_W : 0;
        xs = longint'(xmag >> s);
        ys = longint'(ymag >> s);
        if (dot < 0) xs = -xs;
        if (tr > 0) ys = -ys;
        // vectoring cordic, pre-rotated into the right half plane
        acc = 0;
        if (xs < 0)
        begin
            tmp = xs;
            if (ys >= 0)
            begin
                xs = ys; ys = -tmp; acc = dihed_pkg::QUARTER_ACC;
            end
            else
            begin
                xs = -ys; ys = tmp; acc = -dihed_pkg::QUARTER_ACC;
            end
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys > 0)
            begin
                xs += dx; ys -= dy; acc += longint'(dihed_pkg::atan_entry(i));
            end
            else
            begin
                xs -= dx; ys += dy; acc -= longint'(dihed_pkg::atan_entry(i));
            end
        end
        ang = (acc + 128) >>> dihed_pkg::ROUND_SHIFT;
        if (ang <= -dihed_pkg::HALF_TURN) ang += dihed_pkg::FULL_TURN;
        if (ang > dihed_pkg::HALF_TURN) ang -= dihed_pkg::FULL_TURN;
        r.ang = dihed_pkg::ANGLE_W'(ang);
        r.undef = 1'b0;
        return r;
    endfunction

    function automatic dihed_pkg::dihed_pt_t pt(input int x, input int y, input int z);
        dihed_pkg::dihed_pt_t v;
        v.x = dihed_pkg::COORD_W'(x);
        v.y = dihed_pkg::COORD_W'(y);
        v.z = dihed_pkg::COORD_W'(z);
        return v;
    endfunction

    function automatic dihed_pkg::dihed_pt_t rand_pt(input int span);
        dihed_pkg::dihed_pt_t v;
        if (span == 0)
            v = {dihed_pkg::COORD_W'($urandom), dihed_pkg::COORD_W'($urandom),
                 dihed_pkg::COORD_W'($urandom)};
        else
            v = pt($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span);
        return v;
    endfunction

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_torsions.push_back(torsion_of(cur));
                n_sent++;
            end
            if ((start && !busy) || !start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_quads.size() > 0)
                begin
                    cur <= pending_quads.pop_front();
                    start <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(60, 1);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        torsion_t want;
        if (rst_n && done)
        begin
            if (expected_torsions.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: angle=%0d undefined=%0b", angle, undefined);
            end
            else
            begin
                want = expected_torsions.pop_front();
                n_checked++;
                if (want.undef) n_undef++;
                if (angle !== want.ang || undefined !== want.undef)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch at result %0d: angle exp %0d got %0d, ",
                                  "undefined exp %0b got %0b"},
                                 n_checked, want.ang, angle, want.undef, undefined);
                end
            end
        end
    end

    // watchdog on cycles with no transaction and no result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
                $display("dihedral_angle_four_points regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        quad_t t;
        int mode;
        // directed: reference frame angles, extremes and degenerate geometry
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(0, 256, 256)});
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(0, -256, 256)});
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(-256, 0, 256)});
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(256, 0, 256)});
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(-256, -1, 256)});
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(-256, 1, 256)});
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(256, 256, 0)});
        pending_quads.push_back('0);
        pending_quads.push_back({4{pt(524287, 524287, 524287)}});
        pending_quads.push_back({4{pt(-524288, -524288, -524288)}});
        // axis of zero length
        pending_quads.push_back({pt(100, 5, 9), pt(7, 7, 7), pt(7, 7, 7), pt(-3, 40, 2)});
        // first point on the axis: plane and both projections vanish
        pending_quads.push_back({pt(0, 0, 512), pt(0, 0, 0), pt(0, 0, 256), pt(0, 256, 256)});
        // fourth point on the axis
        pending_quads.push_back({pt(256, 0, 0), pt(0, 0, 0), pt(0, 0, 256), pt(0, 0, -900)});
        pending_quads.push_back({pt(524287, -524288, 524287), pt(-524288, 524287, -524288),
                                 pt(524287, 524287, -524288), pt(-524288, -524288, 524287)});
        pending_quads.push_back({pt(-524288, 524287, 0), pt(524287, -524288, 0),
                                 pt(0, 0, 524287), pt(-524288, -524288, -524288)});
        pending_quads.push_back({pt(524287, 0, -524288), pt(0, -524288, 524287),
                                 pt(-524288, 524287, 524287), pt(524287, 524287, 0)});
        pending_quads.push_back({pt(1, 0, 0), pt(0, 0, 0), pt(0, 0, 1), pt(0, 1, 1)});
        for (int i = 0; i < RANDOM_N; i++)
        begin
            mode = $urandom_range(9);
            t.p1 = rand_pt(0); t.p2 = rand_pt(0); t.p3 = rand_pt(0); t.p4 = rand_pt(0);
            if (mode >= 5 && mode <= 7)
            begin
                t.p2 = rand_pt(SMALL_SPAN);
                t.p1 = rand_pt(SMALL_SPAN);
                t.p3 = rand_pt(SMALL_SPAN);
                t.p4 = rand_pt(SMALL_SPAN);
            end
            else if (mode == 8)
            begin
                // degenerate: coincident or collinear points
                case ($urandom_range(2))
                    0: t.p3 = t.p2;
                    1: t.p1 = t.p3;
                    default: t.p4 = t.p2;
                endcase
            end
            else if (mode == 9)
                t.p4 = t.p1;
            pending_quads.push_back(t);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_quads.size() > 0 || start || expected_torsions.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d transactions, checked %0d results, %0d of them degenerate",
                 n_sent, n_checked, n_undef);
        $display("mismatches: %0d, results still owed: %0d", n_mismatch,
                 expected_torsions.size());
        if (n_mismatch == 0 && expected_torsions.size() == 0)
            $display("dihedral_angle_four_points regression: pass");
        else
            $display("dihedral_angle_four_points regression: fail");
        $finish;
    end
endmodule
